// ===== rtl/ftar_pkg.sv =====
// shared constants, types and register indexes for the fan tachometer block
package ftar_pkg;

    localparam int FAN_COUNT = 5;
    localparam int FAN_IDX_W = (FAN_COUNT > 1) ? $clog2(FAN_COUNT) : 1;

    localparam int FAN_W    = 3;
    localparam int COUNT_W  = 8;
    localparam int EXP_W    = 3;
    localparam int NUM_W    = 21;
    localparam int DIVR_W   = COUNT_W + (1 << EXP_W) - 1;
    localparam int DIV_STEPS = NUM_W;
    localparam int STEP_W   = $clog2(DIV_STEPS);
    localparam int CFG_IDX_W = 2;

    localparam logic [EXP_W-1:0]   EXP_MAX     = '1;
    localparam logic [COUNT_W-1:0] STALL_COUNT = '1;

    localparam logic [NUM_W-1:0]   NUMERATOR_RESET = NUM_W'(1350000);
    localparam logic [COUNT_W-1:0] UPPER_RESET     = COUNT_W'(192);
    localparam logic [COUNT_W-1:0] LOWER_RESET     = COUNT_W'(96);

    localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_UPPER     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOWER     = 2'd2;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } ftar_cmd_t;

    typedef struct packed {
        logic div_done;
    } ftar_sts_t;

endpackage

// ===== rtl/ftar_dp.sv =====
// datapath: config registers, exponent store, auto-ranging and serial divider
module ftar_dp
    import ftar_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ftar_cmd_t             cmd,
    output ftar_sts_t             sts,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [NUM_W-1:0]      cfg_data,
    input  logic [FAN_W-1:0]      fan_number,
    input  logic [COUNT_W-1:0]    tach_count,
    output logic [NUM_W-1:0]      speed_rpm,
    output logic [EXP_W-1:0]      exponent_used,
    output logic [EXP_W-1:0]      exponent_next,
    output logic                  exponent_changed,
    output logic                  zero_count
);

    logic [NUM_W-1:0]   numerator_reg;
    logic [COUNT_W-1:0] upper_reg;
    logic [COUNT_W-1:0] lower_reg;
    logic [EXP_W-1:0]   exp_store_reg [FAN_COUNT];

    logic [NUM_W-1:0]   num_hold_reg;
    logic [NUM_W-1:0]   quo_reg;
    logic [DIVR_W-1:0]  rem_reg;
    logic [DIVR_W-1:0]  divisor_reg;
    logic [STEP_W-1:0]  step_reg;
    logic [EXP_W-1:0]   used_reg;
    logic [EXP_W-1:0]   next_reg;
    logic               changed_reg;
    logic               zero_reg;
    logic               stall_reg;

    logic [NUM_W-1:0]   speed_out_reg;
    logic [EXP_W-1:0]   used_out_reg;
    logic [EXP_W-1:0]   next_out_reg;
    logic               changed_out_reg;
    logic               zero_out_reg;

    logic                 fan_ok;
    logic [FAN_IDX_W-1:0] fan_idx;
    logic [EXP_W-1:0]     exp_cur;
    logic [EXP_W-1:0]     exp_up;
    logic [EXP_W-1:0]     exp_new;
    logic [DIVR_W:0]      trial;
    logic [DIVR_W:0]      diff;
    logic [NUM_W-1:0]     speed_next;

    assign fan_ok  = {1'b0, fan_number} < (FAN_W + 1)'(FAN_COUNT);
    assign fan_idx = FAN_IDX_W'(fan_number);
    assign exp_cur = fan_ok ? exp_store_reg[fan_idx] : '0;

    // auto-ranging: raise first, then lower
    always_comb
    begin
        exp_up = exp_cur;
        if (tach_count > upper_reg && exp_cur < EXP_MAX)
        begin
            exp_up = exp_cur + EXP_W'(1);
        end
        exp_new = exp_up;
        if (tach_count < lower_reg && exp_up != '0)
        begin
            exp_new = exp_up - EXP_W'(1);
        end
    end

    // restoring division, one quotient bit a cycle
    assign trial = {rem_reg, quo_reg[NUM_W-1]};
    assign diff  = trial - {1'b0, divisor_reg};

    always_comb
    begin
        priority if (stall_reg)
        begin
            speed_next = '0;
        end
        else if (zero_reg)
        begin
            speed_next = num_hold_reg;
        end
        else
        begin
            speed_next = quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numerator_reg <= NUMERATOR_RESET;
            upper_reg     <= UPPER_RESET;
            lower_reg     <= LOWER_RESET;
            for (int i = 0; i < FAN_COUNT; i++)
            begin
                exp_store_reg[i] <= '0;
            end
            step_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_NUMERATOR: numerator_reg <= cfg_data;
                    REG_UPPER:     upper_reg     <= cfg_data[COUNT_W-1:0];
                    REG_LOWER:     lower_reg     <= cfg_data[COUNT_W-1:0];
                    default:       ;
                endcase
            end
            if (cmd.load)
            begin
                step_reg <= '0;
                if (fan_ok)
                begin
                    exp_store_reg[fan_idx] <= exp_new;
                end
            end
            else if (cmd.step)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            num_hold_reg <= numerator_reg;
            quo_reg      <= numerator_reg;
            rem_reg      <= '0;
            divisor_reg  <= DIVR_W'(tach_count) << exp_cur;
            used_reg     <= exp_cur;
            next_reg     <= exp_new;
            changed_reg  <= fan_ok && (exp_new != exp_cur);
            zero_reg     <= tach_count == '0;
            stall_reg    <= tach_count == STALL_COUNT;
        end
        else if (cmd.step)
        begin
            if (!diff[DIVR_W])
            begin
                rem_reg <= diff[DIVR_W-1:0];
            end
            else
            begin
                rem_reg <= trial[DIVR_W-1:0];
            end
            quo_reg <= {quo_reg[NUM_W-2:0], ~diff[DIVR_W]};
        end
        if (cmd.publish)
        begin
            speed_out_reg   <= speed_next;
            used_out_reg    <= used_reg;
            next_out_reg    <= next_reg;
            changed_out_reg <= changed_reg;
            zero_out_reg    <= zero_reg;
        end
    end

    assign sts.div_done = step_reg == STEP_W'(DIV_STEPS - 1);

    assign speed_rpm        = speed_out_reg;
    assign exponent_used    = used_out_reg;
    assign exponent_next    = next_out_reg;
    assign exponent_changed = changed_out_reg;
    assign zero_count       = zero_out_reg;

endmodule

// ===== rtl/ftar_ctrl.sv =====
// controller: sequences load, divide and result hand-off
module ftar_ctrl
    import ftar_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_stall,
    output logic      out_valid,
    input  logic      out_stall,
    input  ftar_sts_t sts,
    output ftar_cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_DIVIDE = 3'b010,
        S_FINISH = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        cmd.load    = 1'b0;
        cmd.step    = 1'b0;
        cmd.publish = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DIVIDE;
                end
            end
            S_DIVIDE:
            begin
                cmd.step = 1'b1;
                if (sts.div_done)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        priority if (cmd.publish)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;

    a_accept_starts_divide: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_DIVIDE)
        else $error("accepted item did not start the divider");

    a_divide_runs_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIVIDE && !sts.div_done |=> state_reg == S_DIVIDE)
        else $error("divider left early");

    a_result_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_FINISH))
        else $error("result shown without a finished division");

endmodule

// ===== rtl/fan_tach_autorange_rpm.sv =====
// top level: fan speed from tachometer count with per-fan auto-ranging divisor
// Each item passes through a load step, the bit-serial restoring divider (one quotient bit
// per cycle for the 21-bit numerator) and a finish step that moves the result into the
// output register; a new item is accepted only after that hand-off.
// The result then waits in that register while the next item is taken; a
// stalled result holds off only the final hand-off of the following item.
// The per-fan divisor exponent is updated when the item is accepted.
module fan_tach_autorange_rpm
    import ftar_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [NUM_W-1:0]     cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [FAN_W-1:0]     fan_number,
    input  logic [COUNT_W-1:0]   tach_count,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [NUM_W-1:0]     speed_rpm,
    output logic [EXP_W-1:0]     exponent_used,
    output logic [EXP_W-1:0]     exponent_next,
    output logic                 exponent_changed,
    output logic                 zero_count
);

    ftar_cmd_t cmd;
    ftar_sts_t sts;

    ftar_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ftar_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .fan_number       (fan_number),
        .tach_count       (tach_count),
        .speed_rpm        (speed_rpm),
        .exponent_used    (exponent_used),
        .exponent_next    (exponent_next),
        .exponent_changed (exponent_changed),
        .zero_count       (zero_count)
    );

endmodule
